### sv/uifb_pkg.sv
// Package for the UDP/IPv4 frame builder: header constants, shared types and the
// ones-complement adder used by the payload accumulator and the checksum sequencer.
// No dependencies.
package uifb_pkg;

    // Frame layout and payload limit.
    localparam int unsigned MAX_PAYLOAD = 1472;
    localparam int unsigned HDR_LEN     = 42;
    localparam int unsigned UDP_HDR_LEN = 8;
    localparam int unsigned IP_HDR_LEN  = 20;

    // Fixed header field values.
    localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  IP_VER_IHL    = 8'h45;
    localparam logic [7:0]  IP_TTL        = 8'd64;
    localparam logic [7:0]  IP_PROTO_UDP  = 8'd17;

    // Header byte positions with a special meaning to the control logic.
    localparam logic [5:0] HDR_IDX_IP_CK_HI  = 6'd24;
    localparam logic [5:0] HDR_IDX_UDP_CK_HI = 6'd40;
    localparam logic [5:0] HDR_IDX_LAST      = 6'd41;

    // The checksum sequencer folds one word per step into each sum.
    localparam logic [3:0] CSUM_LAST_STEP = 4'd9;

    // Running payload state.
    typedef struct packed {
        logic [15:0] psum;
        logic [7:0]  held;
        logic        odd;
        logic [10:0] count;
    } t_acc_state;

    // Everything the header needs, captured on the last payload byte.
    typedef struct packed {
        logic [47:0] dst_mac;
        logic [47:0] src_mac;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [15:0] udp_sport;
        logic [15:0] udp_dport;
        logic [15:0] udp_len;
        logic [15:0] ip_len;
        logic [15:0] psum;
        logic [7:0]  held;
        logic        odd;
    } t_hdr_info;

    // Sixteen-bit ones-complement add with end-around carry.
    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'b0, s[16]};
    endfunction

endpackage

### sv/uifb_if.sv
// Valid/ready channel interfaces for the payload input and the frame byte output.
// No dependencies.
interface uifb_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  payload_byte;
    logic        last_byte;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] udp_sport;
    logic [15:0] udp_dport;
    logic [47:0] src_mac;
    logic [47:0] dst_mac;

    modport source (
        output valid, payload_byte, last_byte, src_ip, dst_ip,
               udp_sport, udp_dport, src_mac, dst_mac,
        input  ready
    );
    modport sink (
        input  valid, payload_byte, last_byte, src_ip, dst_ip,
               udp_sport, udp_dport, src_mac, dst_mac,
        output ready
    );
endinterface

interface uifb_out_if;
    logic        valid;
    logic        ready;
    logic [10:0] frame_offset;
    logic [7:0]  frame_byte;
    logic        frame_done;

    modport source (
        output valid, frame_offset, frame_byte, frame_done,
        input  ready
    );
    modport sink (
        input  valid, frame_offset, frame_byte, frame_done,
        output ready
    );
endinterface

### sv/uifb_payload_acc.sv
// Payload accumulator: byte count, pending high byte and running ones-complement sum.
// Depends on uifb_pkg.
module uifb_payload_acc (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_take,
    input  logic                  i_last,
    input  logic [7:0]            i_byte,
    output logic                  o_keep,
    output logic [10:0]           o_offset,
    output uifb_pkg::t_acc_state  o_next
);

    uifb_pkg::t_acc_state r_acc;
    uifb_pkg::t_acc_state n_acc;

    // A byte is kept while the payload is below its maximum length.
    assign o_keep   = r_acc.count < 11'(uifb_pkg::MAX_PAYLOAD);
    assign o_offset = 11'(uifb_pkg::HDR_LEN) + r_acc.count;

    // Pair bytes into big-endian words and fold each completed word into the sum.
    always_comb begin
        n_acc = r_acc;
        if (o_keep) begin
            if (r_acc.odd) begin
                n_acc.psum = uifb_pkg::oc_add(r_acc.psum, {r_acc.held, i_byte});
                n_acc.held = 8'h00;
                n_acc.odd  = 1'b0;
            end else begin
                n_acc.held = i_byte;
                n_acc.odd  = 1'b1;
            end
            n_acc.count = r_acc.count + 11'd1;
        end
    end

    assign o_next = n_acc;

    // The state clears once the last byte of a datagram is transferred.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_take) begin
            if (i_last) begin
                r_acc <= '0;
            end else begin
                r_acc <= n_acc;
            end
        end
    end

endmodule

### sv/uifb_csum_seq.sv
// Checksum sequencer: builds the IPv4 header and UDP checksums one word per cycle.
// Depends on uifb_pkg.
module uifb_csum_seq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  uifb_pkg::t_hdr_info  i_info,
    output logic                 o_done,
    output logic [15:0]          o_ip_ck,
    output logic [15:0]          o_udp_ck
);

    logic        r_busy;
    logic [3:0]  r_step;
    logic [15:0] r_ip_acc;
    logic [15:0] r_udp_acc;
    logic [15:0] ip_word;
    logic [15:0] udp_word;
    logic [15:0] udp_inv;

    // Word fed into each sum at the current step; a zero word leaves a sum as it is.
    always_comb begin
        case (r_step)
            4'd0:    ip_word = i_info.ip_len;
            4'd1:    ip_word = {uifb_pkg::IP_TTL, uifb_pkg::IP_PROTO_UDP};
            4'd2:    ip_word = i_info.src_ip[31:16];
            4'd3:    ip_word = i_info.src_ip[15:0];
            4'd4:    ip_word = i_info.dst_ip[31:16];
            4'd5:    ip_word = i_info.dst_ip[15:0];
            default: ip_word = 16'h0000;
        endcase
    end

    always_comb begin
        case (r_step)
            4'd0:    udp_word = i_info.odd ? {i_info.held, 8'h00} : 16'h0000;
            4'd1:    udp_word = i_info.src_ip[31:16];
            4'd2:    udp_word = i_info.src_ip[15:0];
            4'd3:    udp_word = i_info.dst_ip[31:16];
            4'd4:    udp_word = i_info.dst_ip[15:0];
            4'd5:    udp_word = {8'h00, uifb_pkg::IP_PROTO_UDP};
            4'd6:    udp_word = i_info.udp_len;
            4'd7:    udp_word = i_info.udp_sport;
            4'd8:    udp_word = i_info.udp_dport;
            4'd9:    udp_word = i_info.udp_len;
            default: udp_word = 16'h0000;
        endcase
    end

    // Step counter and the two running sums.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= '0;
        end else if (r_busy) begin
            r_step <= r_step + 4'd1;
            if (r_step == uifb_pkg::CSUM_LAST_STEP) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ip_acc  <= {uifb_pkg::IP_VER_IHL, 8'h00};
            r_udp_acc <= i_info.psum;
        end else if (r_busy) begin
            r_ip_acc  <= uifb_pkg::oc_add(r_ip_acc, ip_word);
            r_udp_acc <= uifb_pkg::oc_add(r_udp_acc, udp_word);
        end
    end

    // A UDP checksum that comes out as zero is sent as all ones.
    assign udp_inv  = ~r_udp_acc;
    assign o_ip_ck  = ~r_ip_acc;
    assign o_udp_ck = (udp_inv == 16'h0000) ? 16'hFFFF : udp_inv;
    assign o_done   = !r_busy && !i_start;

endmodule

### sv/udp_ipv4_frame_builder.sv
// UDP/IPv4/Ethernet frame builder. A kept payload byte appears at the output in the cycle after
// its transfer. Throughput: one payload byte per cycle while the output accepts; after the last
// byte the 42 header bytes follow at one per cycle, likewise held by back-pressure, and no input
// is taken until the final header byte is loaded. The checksum sequencer runs hidden behind the
// first header bytes. Reset is synchronous, active low,
// and clears the payload state, the control state and the output valid.
module udp_ipv4_frame_builder (
    input  logic              i_clk,
    input  logic              i_rst_n,
    uifb_in_if.sink           i_in,
    uifb_out_if.source        o_out
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_HDR  = 2'b10
    } t_state;

    t_state               r_state;
    t_state               n_state;
    logic [5:0]           r_hdr_idx;
    logic [5:0]           n_hdr_idx;
    logic                 r_out_valid;
    logic                 n_out_valid;
    logic [10:0]          r_out_offset;
    logic [10:0]          n_out_offset;
    logic [7:0]           r_out_byte;
    logic [7:0]           n_out_byte;
    logic                 r_out_done;
    logic                 n_out_done;
    logic                 r_csum_start;
    uifb_pkg::t_hdr_info  r_info;

    logic                 out_free;
    logic                 take;
    logic                 keep;
    logic [10:0]          pay_offset;
    uifb_pkg::t_acc_state acc_next;
    logic                 csum_done;
    logic [15:0]          ip_ck;
    logic [15:0]          udp_ck;
    logic [7:0]           hdr_byte;

    // Input is taken while no header is in flight and the output register can move.
    assign out_free   = !r_out_valid || o_out.ready;
    assign i_in.ready = (r_state == ST_IDLE) && out_free;
    assign take       = i_in.valid && i_in.ready;

    uifb_payload_acc u_acc (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (take),
        .i_last   (i_in.last_byte),
        .i_byte   (i_in.payload_byte),
        .o_keep   (keep),
        .o_offset (pay_offset),
        .o_next   (acc_next)
    );

    // Capture addresses, lengths and the final payload sum on the last byte.
    always_ff @(posedge i_clk) begin
        if (take && i_in.last_byte) begin
            r_info.dst_mac   <= i_in.dst_mac;
            r_info.src_mac   <= i_in.src_mac;
            r_info.src_ip    <= i_in.src_ip;
            r_info.dst_ip    <= i_in.dst_ip;
            r_info.udp_sport <= i_in.udp_sport;
            r_info.udp_dport <= i_in.udp_dport;
            r_info.udp_len   <= 16'(uifb_pkg::UDP_HDR_LEN) + {5'b0, acc_next.count};
            r_info.ip_len    <= 16'(uifb_pkg::IP_HDR_LEN + uifb_pkg::UDP_HDR_LEN)
                                + {5'b0, acc_next.count};
            r_info.psum      <= acc_next.psum;
            r_info.held      <= acc_next.held;
            r_info.odd       <= acc_next.odd;
        end
    end

    uifb_csum_seq u_csum (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_csum_start),
        .i_info   (r_info),
        .o_done   (csum_done),
        .o_ip_ck  (ip_ck),
        .o_udp_ck (udp_ck)
    );

    // Header byte for the current header position, most significant byte first.
    always_comb begin
        case (r_hdr_idx)
            6'd0:    hdr_byte = r_info.dst_mac[47:40];
            6'd1:    hdr_byte = r_info.dst_mac[39:32];
            6'd2:    hdr_byte = r_info.dst_mac[31:24];
            6'd3:    hdr_byte = r_info.dst_mac[23:16];
            6'd4:    hdr_byte = r_info.dst_mac[15:8];
            6'd5:    hdr_byte = r_info.dst_mac[7:0];
            6'd6:    hdr_byte = r_info.src_mac[47:40];
            6'd7:    hdr_byte = r_info.src_mac[39:32];
            6'd8:    hdr_byte = r_info.src_mac[31:24];
            6'd9:    hdr_byte = r_info.src_mac[23:16];
            6'd10:   hdr_byte = r_info.src_mac[15:8];
            6'd11:   hdr_byte = r_info.src_mac[7:0];
            6'd12:   hdr_byte = uifb_pkg::ETH_TYPE_IPV4[15:8];
            6'd13:   hdr_byte = uifb_pkg::ETH_TYPE_IPV4[7:0];
            6'd14:   hdr_byte = uifb_pkg::IP_VER_IHL;
            6'd16:   hdr_byte = r_info.ip_len[15:8];
            6'd17:   hdr_byte = r_info.ip_len[7:0];
            6'd22:   hdr_byte = uifb_pkg::IP_TTL;
            6'd23:   hdr_byte = uifb_pkg::IP_PROTO_UDP;
            6'd24:   hdr_byte = ip_ck[15:8];
            6'd25:   hdr_byte = ip_ck[7:0];
            6'd26:   hdr_byte = r_info.src_ip[31:24];
            6'd27:   hdr_byte = r_info.src_ip[23:16];
            6'd28:   hdr_byte = r_info.src_ip[15:8];
            6'd29:   hdr_byte = r_info.src_ip[7:0];
            6'd30:   hdr_byte = r_info.dst_ip[31:24];
            6'd31:   hdr_byte = r_info.dst_ip[23:16];
            6'd32:   hdr_byte = r_info.dst_ip[15:8];
            6'd33:   hdr_byte = r_info.dst_ip[7:0];
            6'd34:   hdr_byte = r_info.udp_sport[15:8];
            6'd35:   hdr_byte = r_info.udp_sport[7:0];
            6'd36:   hdr_byte = r_info.udp_dport[15:8];
            6'd37:   hdr_byte = r_info.udp_dport[7:0];
            6'd38:   hdr_byte = r_info.udp_len[15:8];
            6'd39:   hdr_byte = r_info.udp_len[7:0];
            6'd40:   hdr_byte = udp_ck[15:8];
            6'd41:   hdr_byte = udp_ck[7:0];
            default: hdr_byte = 8'h00;
        endcase
    end

    // Output register and header sequencing.
    always_comb begin
        n_state      = r_state;
        n_hdr_idx    = r_hdr_idx;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_offset = r_out_offset;
        n_out_byte   = r_out_byte;
        n_out_done   = r_out_done;
        case (r_state)
            ST_IDLE: begin
                if (take) begin
                    if (keep) begin
                        n_out_valid  = 1'b1;
                        n_out_offset = pay_offset;
                        n_out_byte   = i_in.payload_byte;
                        n_out_done   = 1'b0;
                    end
                    if (i_in.last_byte) begin
                        n_state   = ST_HDR;
                        n_hdr_idx = '0;
                    end
                end
            end
            ST_HDR: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_offset = {5'b0, r_hdr_idx};
                    n_out_byte   = hdr_byte;
                    n_out_done   = (r_hdr_idx == uifb_pkg::HDR_IDX_LAST);
                    n_hdr_idx    = r_hdr_idx + 6'd1;
                    if (r_hdr_idx == uifb_pkg::HDR_IDX_LAST) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_hdr_idx    <= '0;
            r_out_valid  <= 1'b0;
            r_csum_start <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_hdr_idx    <= n_hdr_idx;
            r_out_valid  <= n_out_valid;
            r_csum_start <= take && i_in.last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_offset <= n_out_offset;
        r_out_byte   <= n_out_byte;
        r_out_done   <= n_out_done;
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.frame_offset = r_out_offset;
    assign o_out.frame_byte   = r_out_byte;
    assign o_out.frame_done   = r_out_done;

    // The checksums must be final before their header bytes are loaded.
    a_ip_ck_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_HDR && out_free && r_hdr_idx == uifb_pkg::HDR_IDX_IP_CK_HI)
        |-> csum_done)
        else $error("IP checksum byte loaded before the checksum was final");

    a_udp_ck_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_HDR && out_free && r_hdr_idx == uifb_pkg::HDR_IDX_UDP_CK_HI)
        |-> csum_done)
        else $error("UDP checksum byte loaded before the checksum was final");

    // A last byte starts the header at its first position.
    a_hdr_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && i_in.last_byte) |=> (r_state == ST_HDR && r_hdr_idx == 6'd0))
        else $error("Header burst did not start after the last payload byte");

    // The frame-complete flag only appears on the final header byte.
    a_done_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.frame_done)
        |-> (o_out.frame_offset == {5'b0, uifb_pkg::HDR_IDX_LAST}))
        else $error("Frame done flagged away from the final header byte");

endmodule
